@@ rtl/grid_edge_rewire_store_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid edge rewire store
// Concurrent checks that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GRID_EDGE_REWIRE_STORE_MACROS_SVH
`define GRID_EDGE_REWIRE_STORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define GERS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grid edge rewire store: check failed");

// Next-cycle implication
`define GERS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grid edge rewire store: check failed");

`else

`define GERS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`define GERS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/gers_pkg.sv @@
// ----------------------------------------------------------------------------
// gers_pkg
// Shared types, codes and direction tables of the grid edge rewire store.
// ----------------------------------------------------------------------------
`default_nettype none

package gers_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int CFG_W       = 7;
	localparam int CFG_RESET   = 64;
	localparam int COORD_W     = 7;
	localparam int NCOORD_W    = 8;
	localparam int MASK_W      = 8;
	localparam int HAND_W      = 3;
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 2;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_REWIRE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_EDGE = 2'd1,
		ST_OOB  = 2'd2
	} status_t;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	// Memory phase requested by the controller
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CLEAR,
		PH_LOOK,
		PH_OLD,
		PH_NEW
	} phase_t;

	typedef struct packed {
		logic   load_in;
		phase_t phase;
		logic   out_load;
		logic   out_from_res;
		logic   res_save;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rewire_go;
	} dp_stat_t;

	// Row step of direction h, clockwise from the top
	function automatic logic signed [1:0] step_row(input logic [HAND_W-1:0] h);
		logic signed [1:0] s;
		unique case (h)
			3'd0:    s = -2'sd1;
			3'd1:    s = -2'sd1;
			3'd2:    s = 2'sd0;
			3'd3:    s = 2'sd1;
			3'd4:    s = 2'sd1;
			3'd5:    s = 2'sd1;
			3'd6:    s = 2'sd0;
			default: s = -2'sd1;
		endcase
		return s;
	endfunction

	// Column step of direction h
	function automatic logic signed [1:0] step_col(input logic [HAND_W-1:0] h);
		logic signed [1:0] s;
		unique case (h)
			3'd0:    s = 2'sd0;
			3'd1:    s = 2'sd1;
			3'd2:    s = 2'sd1;
			3'd3:    s = 2'sd1;
			3'd4:    s = 2'sd0;
			3'd5:    s = -2'sd1;
			3'd6:    s = -2'sd1;
			default: s = -2'sd1;
		endcase
		return s;
	endfunction

	// Opposite direction
	function automatic logic [HAND_W-1:0] rev_hand(input logic [HAND_W-1:0] h);
		return HAND_W'(h + HAND_W'(4));
	endfunction

endpackage

`default_nettype wire

@@ rtl/gers_ram.sv @@
// ----------------------------------------------------------------------------
// gers_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gers_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

@@ rtl/gers_ctrl.sv @@
// ----------------------------------------------------------------------------
// gers_ctrl
// Command sequencer: clearing pass, lookup, rewire steps, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "grid_edge_rewire_store_macros.svh"

module gers_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output gers_pkg::ctl_cmd_t      cmd,
	input  wire gers_pkg::dp_stat_t stat
);
	import gers_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_OLD,
		S_NEW,
		S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q, m_tvalid_d;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d          = state_q;
		cmd.load_in      = 1'b0;
		cmd.phase        = PH_IDLE;
		cmd.out_load     = 1'b0;
		cmd.out_from_res = 1'b0;
		cmd.res_save     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.phase = PH_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.phase = PH_LOOK;
				if (stat.rewire_go) begin
					state_d = S_OLD;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.res_save = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_OLD: begin
				cmd.phase = PH_OLD;
				state_d   = S_NEW;
			end
			S_NEW: begin
				cmd.phase = PH_NEW;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.res_save = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_res = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		m_tvalid_d = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// A new result never overwrites one that is still waiting
	`GERS_ASSERT_IMPL(a_out_free, clk, arst_n, cmd.out_load, !m_tvalid_q || m_tready)
	// Park a result only while the output beat is stalled
	`GERS_ASSERT_IMPL(a_park_stall, clk, arst_n, cmd.res_save, m_tvalid_q && !m_tready)
	// A parked result always sits behind a pending output beat
	`GERS_ASSERT_IMPL(a_fin_pending, clk, arst_n, state_q == S_FIN, m_tvalid_q)
	// The neighbor update steps run back to back after a lookup
	`GERS_ASSERT_NEXT(a_old_to_new, clk, arst_n, state_q == S_OLD, state_q == S_NEW)

endmodule

`default_nettype wire

@@ rtl/gers_dp.sv @@
// ----------------------------------------------------------------------------
// gers_dp
// Datapath: item registers, bounds checks, cell memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gers_dp #(
	parameter int MAX_ROWS = gers_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gers_pkg::DEF_MAX_COLS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [gers_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic [gers_pkg::CFG_W-1:0]          grid_rows,
	input  wire logic [gers_pkg::CFG_W-1:0]          grid_cols,
	input  wire gers_pkg::ctl_cmd_t                  cmd,
	output gers_pkg::dp_stat_t                       stat,
	output logic      [gers_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import gers_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	function automatic logic on_grid(
		input logic signed [NCOORD_W-1:0] r,
		input logic signed [NCOORD_W-1:0] c,
		input logic [CFG_W-1:0]           nr,
		input logic [CFG_W-1:0]           nc
	);
		return !r[NCOORD_W-1] && !c[NCOORD_W-1]
			&& (r[COORD_W-1:0] < nr) && (c[COORD_W-1:0] < nc)
			&& (32'(r[COORD_W-1:0]) < 32'(MAX_ROWS))
			&& (32'(c[COORD_W-1:0]) < 32'(MAX_COLS));
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(
		input logic signed [NCOORD_W-1:0] r,
		input logic signed [NCOORD_W-1:0] c
	);
		return ADDR_W'(32'(r[COORD_W-1:0]) * 32'(MAX_COLS) + 32'(c[COORD_W-1:0]));
	endfunction

	// Unpack input beat
	cmd_code_t                    in_cmd;
	logic signed [COORD_W-1:0]    in_row, in_col;
	logic        [MASK_W-1:0]     in_val;
	logic        [HAND_W-1:0]     in_oh, in_nh;
	logic signed [NCOORD_W-1:0]   row_x, col_x, orow, ocol, nrow, ncol;
	logic        [ADDR_W-1:0]     in_addr;

	assign in_cmd = cmd_code_t'(s_tdata[1:0]);
	assign in_row = s_tdata[8:2];
	assign in_col = s_tdata[15:9];
	assign in_val = s_tdata[23:16];
	assign in_oh  = s_tdata[26:24];
	assign in_nh  = s_tdata[29:27];

	assign row_x   = NCOORD_W'(in_row);
	assign col_x   = NCOORD_W'(in_col);
	assign orow    = row_x + NCOORD_W'(step_row(in_oh));
	assign ocol    = col_x + NCOORD_W'(step_col(in_oh));
	assign nrow    = row_x + NCOORD_W'(step_row(in_nh));
	assign ncol    = col_x + NCOORD_W'(step_col(in_nh));
	assign in_addr = cell_addr(row_x, col_x);

	// Item registers
	cmd_code_t            cmd_q;
	logic [MASK_W-1:0]    val_q;
	logic [HAND_W-1:0]    oh_q, nh_q;
	logic                 src_in_q, old_in_q, new_in_q;
	logic [ADDR_W-1:0]    src_addr_q, old_addr_q, new_addr_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q      <= in_cmd;
			val_q      <= in_val;
			oh_q       <= in_oh;
			nh_q       <= in_nh;
			src_in_q   <= on_grid(row_x, col_x, grid_rows, grid_cols);
			old_in_q   <= on_grid(orow, ocol, grid_rows, grid_cols);
			new_in_q   <= on_grid(nrow, ncol, grid_rows, grid_cols);
			src_addr_q <= in_addr;
			old_addr_q <= cell_addr(orow, ocol);
			new_addr_q <= cell_addr(nrow, ncol);
		end
	end

	// Clearing sweep after reset
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.phase == PH_CLEAR && !stat.clr_last) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	assign stat.clr_last = (clr_q == ADDR_W'(DEPTH - 1));

	// Cell memory
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [MASK_W-1:0] wr_data, rd_data;
	logic [MASK_W-1:0] obit, nbit, orev, nrev;

	assign obit = MASK_W'(1) << oh_q;
	assign nbit = MASK_W'(1) << nh_q;
	assign orev = MASK_W'(1) << rev_hand(oh_q);
	assign nrev = MASK_W'(1) << rev_hand(nh_q);

	assign stat.rewire_go = (cmd_q == CMD_REWIRE) && src_in_q && rd_data[oh_q]
		&& !rd_data[nh_q] && old_in_q && new_in_q;

	always_comb begin
		unique case (cmd.phase)
			PH_LOOK: rd_addr = old_addr_q;
			PH_OLD:  rd_addr = new_addr_q;
			default: rd_addr = in_addr;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = src_addr_q;
		wr_data = '0;
		unique case (cmd.phase)
			PH_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			PH_LOOK: begin
				wr_en   = ((cmd_q == CMD_WRITE) && src_in_q) || stat.rewire_go;
				wr_data = (cmd_q == CMD_WRITE) ? val_q : ((rd_data & ~obit) | nbit);
			end
			PH_OLD: begin
				wr_en   = 1'b1;
				wr_addr = old_addr_q;
				wr_data = rd_data & ~orev;
			end
			PH_NEW: begin
				wr_en   = 1'b1;
				wr_addr = new_addr_q;
				wr_data = rd_data | nrev;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	gers_ram #(
		.WIDTH (MASK_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result of the current step
	status_t           res_status;
	logic [MASK_W-1:0] res_value;

	always_comb begin
		res_status = ST_OK;
		res_value  = '0;
		if (cmd.phase == PH_LOOK) begin
			unique case (cmd_q)
				CMD_READ: begin
					if (!src_in_q) begin
						res_status = ST_OOB;
					end else begin
						res_value = rd_data;
					end
				end
				CMD_WRITE: begin
					if (!src_in_q) begin
						res_status = ST_OOB;
					end
				end
				CMD_REWIRE: begin
					if (!src_in_q) begin
						res_status = ST_OOB;
					end else if (!rd_data[oh_q] || rd_data[nh_q]) begin
						res_status = ST_EDGE;
					end else if (!old_in_q || !new_in_q) begin
						res_status = ST_OOB;
					end
				end
				CMD_NOP: begin
					res_status = ST_OK;
				end
				default: begin
					res_status = ST_OK;
				end
			endcase
		end
	end

	// Parked result and output register
	status_t           res_status_q;
	logic [MASK_W-1:0] res_value_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk) begin
		if (cmd.res_save) begin
			res_status_q <= res_status;
			res_value_q  <= res_value;
		end
		if (cmd.out_load) begin
			m_tdata_q <= cmd.out_from_res ? OUT_TDATA_W'({res_value_q, res_status_q})
				: OUT_TDATA_W'({res_value, res_status});
		end
	end

	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

@@ rtl/grid_edge_rewire_store.sv @@
// ----------------------------------------------------------------------------
// grid_edge_rewire_store
// Grid of 8-bit edge masks with read, write and edge rewire commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter as beats on the s_ stream and each one returns exactly
//   one result beat on the m_ stream (status and, for a read, the mask).
//   The grid size in use is set through the APB port: grid_rows at 0x0,
//   grid_cols at 0x4; values above MAX_ROWS or MAX_COLS act as the maximum.
//   Change them only while no command is in flight.
//   Steps: the cell memory has one write and one read port with a
//   registered read, so a read, write or rejected command needs only the
//   lookup of the source, while a completed rewire then runs a
//   read-modify-write of the old and then of the new neighbor.
//   One command is in flight at a time.
//   Reset: the controller sweeps the memory to zero, one cell per cycle,
//   over all MAX_ROWS*MAX_COLS cells (4096 at the defaults); s_tready
//   stays low meanwhile. APB writes are taken at any time.
//   Stall: a result waits in the output register while m_tready is low;
//   the next command is still accepted and finishes into a holding
//   register, and s_tready drops until the waiting beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_edge_rewire_store #(
	parameter int MAX_ROWS = gers_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gers_pkg::DEF_MAX_COLS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// cmd[1:0], row[8:2], col[15:9], cell_value[23:16], old_hand[26:24],
	// new_hand[29:27], zero fill [31:30]
	input  wire logic [gers_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// status[1:0], read_value[9:2], zero fill [15:10]
	output logic      [gers_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [gers_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [gers_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [gers_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);
	import gers_pkg::*;

	// Configuration registers
	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(CFG_RESET);
			grid_cols_q <= CFG_W'(CFG_RESET);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROWS: grid_rows_q <= pwdata[CFG_W-1:0];
				REG_COLS: grid_cols_q <= pwdata[CFG_W-1:0];
				default:  grid_rows_q <= grid_rows_q;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (cfg_idx)
			REG_ROWS: prdata = APB_DATA_W'(grid_rows_q);
			REG_COLS: prdata = APB_DATA_W'(grid_cols_q);
			default:  prdata = '0;
		endcase
	end

	// Controller and datapath
	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	gers_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (ctl_cmd),
		.stat     (dp_stat)
	);

	gers_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.grid_rows (grid_rows_q),
		.grid_cols (grid_cols_q),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the grid edge rewire store
// Streams read, write and rewire commands into the block and checks each
// result beat against a cycle-free model of the edge grid. The run covers
// several grid sizes set over APB, including zero, one-wide and oversized
// settings, and random stalls on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import gers_pkg::*;

	localparam int QUIET_LIMIT = 20000;   // covers the reset sweep of the cell memory
	localparam int TAIL_CYCLES = 8;       // extra wait after the last due result has left

	// Command beat, last field in the lowest bits
	typedef struct packed {
		logic [1:0] pad;
		logic [2:0] new_hand;
		logic [2:0] old_hand;
		logic [7:0] cell_value;
		logic [6:0] col;
		logic [6:0] row;
		cmd_code_t  cmd;
	} grid_cmd_t;

	// Result beat
	typedef struct packed {
		logic [5:0] pad;
		logic [7:0] read_value;
		status_t    status;
	} grid_result_t;

	typedef struct packed {
		grid_cmd_t    cmd;
		grid_result_t want;
	} awaited_t;

	// Tracks the edge masks and the grid size, and holds the results that are due
	class grid_tracker;
		logic [7:0] cell_mask [DEF_MAX_ROWS*DEF_MAX_COLS];
		int         n_rows = CFG_RESET;
		int         n_cols = CFG_RESET;
		int         errors = 0;
		awaited_t   due_results[$];
		int         row_delta[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
		int         col_delta[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

		function new();
			foreach (cell_mask[i]) cell_mask[i] = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [6:0] value);
			if (idx == REG_ROWS) n_rows = value;
			else n_cols = value;
		endfunction

		function int rows_in_use();
			return (n_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : n_rows;
		endfunction

		function int cols_in_use();
			return (n_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : n_cols;
		endfunction

		function bit in_grid(int r, int c);
			return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
		endfunction

		function logic [7:0] mask_at(int r, int c);
			return cell_mask[r*DEF_MAX_COLS + c];
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Apply one accepted command and queue the result it must produce
		function void note_command(grid_cmd_t c);
			awaited_t   a;
			int         r, cc, orr, occ, nrr, ncc;
			logic [7:0] src, obit, nbit;
			a.cmd = c;
			a.want = '0;
			a.want.status = ST_OK;
			r = $signed(c.row);
			cc = $signed(c.col);
			case (c.cmd)
				CMD_READ: begin
					if (!in_grid(r, cc)) a.want.status = ST_OOB;
					else a.want.read_value = mask_at(r, cc);
				end
				CMD_WRITE: begin
					if (!in_grid(r, cc)) a.want.status = ST_OOB;
					else cell_mask[r*DEF_MAX_COLS + cc] = c.cell_value;
				end
				CMD_REWIRE: begin
					if (!in_grid(r, cc)) begin
						a.want.status = ST_OOB;
					end else begin
						src = mask_at(r, cc);
						obit = 8'b1 << c.old_hand;
						nbit = 8'b1 << c.new_hand;
						orr = r + row_delta[c.old_hand];
						occ = cc + col_delta[c.old_hand];
						nrr = r + row_delta[c.new_hand];
						ncc = cc + col_delta[c.new_hand];
						if ((src & obit) == 0 || (src & nbit) != 0) begin
							a.want.status = ST_EDGE;
						end else if (!in_grid(orr, occ) || !in_grid(nrr, ncc)) begin
							a.want.status = ST_OOB;
						end else begin
							// source first, then drop the old back edge, then add the new one
							cell_mask[r*DEF_MAX_COLS + cc] = (src & ~obit) | nbit;
							cell_mask[orr*DEF_MAX_COLS + occ] &= ~(8'b1 << 3'(c.old_hand + 3'd4));
							cell_mask[nrr*DEF_MAX_COLS + ncc] |= 8'b1 << 3'(c.new_hand + 3'd4);
						end
					end
				end
				default: ;   // unused code: plain OK, no change
			endcase
			due_results.push_back(a);
		endfunction

		function void check_result(grid_result_t got);
			awaited_t a;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: status %0d value %02h",
						got.status, got.read_value);
				return;
			end
			a = due_results.pop_front();
			if (got.status !== a.want.status || got.read_value !== a.want.read_value) begin
				errors++;
				if (errors <= 10)
					$display("mismatch cmd %0d row %0d col %0d val %02h hands %0d->%0d: %s",
						a.cmd.cmd, $signed(a.cmd.row), $signed(a.cmd.col),
						a.cmd.cell_value, a.cmd.old_hand, a.cmd.new_hand,
						$sformatf("want status %0d value %02h, got status %0d value %02h",
							a.want.status, a.want.read_value, got.status, got.read_value));
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	grid_tracker grid = new();
	int          send_idle = 29;   // percent of cycles the sender holds off
	int          recv_idle = 76;   // percent of cycles the receiver stalls
	int          quiet_cycles = 0;

	grid_edge_rewire_store uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Receiver: stall at random, at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Check every result beat as it leaves the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			grid.check_result(grid_result_t'(m_tdata));
	end

	// Watchdog: end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one command beat, idling first at the sender's rate; valid stays
	// high after the accept so back-to-back beats never toggle it
	task automatic push_command(input grid_cmd_t c);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= c;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		grid.note_command(c);
	endtask

	task automatic issue(input cmd_code_t cmd, input int row, input int col,
			input int value, input int oh, input int nh);
		grid_cmd_t c;
		c = '0;
		c.cmd = cmd;
		c.row = 7'(row);
		c.col = 7'(col);
		c.cell_value = 8'(value);
		c.old_hand = 3'(oh);
		c.new_hand = 3'(nh);
		push_command(c);
	endtask

	// Drop valid and wait until every due result has left the block
	task automatic settle();
		s_tvalid <= 1'b0;
		while (grid.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Setup phase, access phase, then an idle gap; upper data bits are noise
	task automatic apb_write(input reg_idx_t idx, input logic [6:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(int'(idx) * 4);
		pwdata <= {25'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		grid.set_reg(idx, value);
	endtask

	task automatic configure(input int rows, input int cols);
		settle();
		apb_write(REG_ROWS, 7'(rows));
		apb_write(REG_COLS, 7'(cols));
	endtask

	// Coordinate near the hot window, now and then just outside or anywhere
	function automatic int pick_coord(int lim, int anchor);
		int p;
		p = $urandom_range(99);
		if (lim == 0 || p < 6) return int'($signed(7'($urandom)));
		if (p < 12) return $urandom_range(1) ? lim : -1;
		return (anchor + $urandom_range(3)) % lim;
	endfunction

	function automatic int pick_anchor(int lim);
		if (lim <= 4) return 0;
		case ($urandom_range(2))
			0: return 0;
			1: return lim - 4;
			default: return $urandom_range(lim - 1);
		endcase
	endfunction

	// Direction whose bit in the mask equals want, from a random start
	function automatic logic [2:0] pick_hand(logic [7:0] m, logic want);
		int start;
		start = $urandom_range(7);
		for (int k = 0; k < 8; k++)
			if (m[(start + k) % 8] == want) return 3'((start + k) % 8);
		return 3'(start);
	endfunction

	// Mostly rewires of existing edges to free directions, mixed with
	// writes that seed edges, reads that observe, and a little noise
	task automatic random_command(input int anchor_r, input int anchor_c);
		grid_cmd_t  c;
		int         p, r, cc;
		logic [7:0] m;
		p = $urandom_range(99);
		if (p < 6) begin
			c = grid_cmd_t'({2'b00, 30'($urandom)});
		end else begin
			r = pick_coord(grid.rows_in_use(), anchor_r);
			cc = pick_coord(grid.cols_in_use(), anchor_c);
			c = '0;
			c.row = 7'(r);
			c.col = 7'(cc);
			c.cell_value = 8'($urandom);
			c.old_hand = 3'($urandom);
			c.new_hand = 3'($urandom);
			if (p < 34) begin
				c.cmd = CMD_WRITE;
			end else if (p < 54) begin
				c.cmd = CMD_READ;
			end else begin
				c.cmd = CMD_REWIRE;
				if (grid.in_grid(r, cc) && $urandom_range(9) < 8) begin
					m = grid.mask_at(r, cc);
					c.old_hand = pick_hand(m, 1'b1);
					c.new_hand = pick_hand(m, 1'b0);
				end
			end
		end
		push_command(c);
	endtask

	initial begin
		int seg_rows[8];
		int seg_cols[8];
		int ar, ac;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: default 64x64 grid, memory cleared by reset
		issue(CMD_READ, 0, 0, 8'h00, 0, 0);
		issue(CMD_WRITE, 0, 0, 8'hFF, 7, 7);
		issue(CMD_READ, 0, 0, 8'h00, 0, 0);
		issue(CMD_WRITE, 63, 63, 8'hA5, 0, 0);
		issue(CMD_READ, -64, 63, 8'hFF, 7, 0);          // row far below zero
		issue(CMD_WRITE, 5, -1, 8'h00, 0, 7);           // column just outside
		issue(CMD_REWIRE, -1, -64, 8'h00, 0, 1);
		issue(CMD_REWIRE, 0, 0, 8'h00, 3, 5);           // new edge already there
		issue(CMD_REWIRE, 0, 0, 8'h00, 4, 4);           // same direction twice
		issue(CMD_WRITE, 10, 10, 8'h01, 0, 0);
		issue(CMD_REWIRE, 10, 10, 8'h00, 0, 4);         // clean move, up to down
		issue(CMD_READ, 9, 10, 8'h00, 0, 0);
		issue(CMD_READ, 11, 10, 8'h00, 0, 0);
		issue(CMD_READ, 10, 10, 8'h00, 0, 0);
		issue(CMD_REWIRE, 10, 10, 8'h00, 0, 2);         // old edge now gone
		issue(CMD_WRITE, 0, 5, 8'h80, 0, 0);
		issue(CMD_REWIRE, 0, 5, 8'h00, 7, 2);           // old neighbor off the top
		issue(CMD_WRITE, 63, 20, 8'h01, 0, 0);
		issue(CMD_REWIRE, 63, 20, 8'h00, 0, 3);         // new neighbor off the bottom
		issue(CMD_NOP, -64, 63, 8'hFF, 7, 7);

		// Zero rows: nothing is in bounds
		configure(0, 64);
		issue(CMD_READ, 0, 0, 8'h00, 0, 0);
		issue(CMD_REWIRE, 0, 0, 8'h00, 0, 1);
		// Oversized registers act as the maximum
		configure(127, 127);
		issue(CMD_READ, 63, 63, 8'h00, 0, 0);
		// Shrink, then grow back: the far corner must keep its mask
		configure(2, 3);
		issue(CMD_READ, 63, 63, 8'h00, 0, 0);
		configure(64, 64);
		issue(CMD_READ, 63, 63, 8'h00, 0, 0);

		// Random segments, each with its own grid size
		seg_rows = '{4, 127, 1, 64, $urandom_range(1, 127), 0, $urandom_range(2, 8), 64};
		seg_cols = '{5, 127, 64, 1, $urandom_range(1, 127), $urandom_range(1, 127),
			$urandom_range(2, 8), 64};
		for (int s = 0; s < 8; s++) begin
			// first sender-light/receiver-heavy, then swapped, then no idling
			send_idle = (s < 3) ? 29 : (s < 6) ? 76 : 0;
			recv_idle = (s < 3) ? 76 : (s < 6) ? 29 : 0;
			configure(seg_rows[s], seg_cols[s]);
			ar = 0;
			ac = 0;
			for (int i = 0; i < ((seg_rows[s] == 0) ? 40 : 130); i++) begin
				if (i % 40 == 0) begin
					ar = pick_anchor(grid.rows_in_use());
					ac = pick_anchor(grid.cols_in_use());
				end
				// hold the sender now and then until the block runs dry
				if ($urandom_range(149) == 0) settle();
				random_command(ar, ac);
			end
		end

		settle();
		if (grid.errors == 0 && grid.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
